// ===== rtl/ppt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point-in-polygon package
// Shared widths, types and codes for the polygon vertex ring and edge unit.
// ----------------------------------------------------------------------------
package ppt_pkg;

   localparam int COORD_WIDTH  = 16;
   localparam int MAX_VERTICES = 64;
   localparam int INDEX_WIDTH  = 6;
   localparam int COUNT_WIDTH  = 7;

   localparam int STEP_WIDTH   = $clog2(MAX_VERTICES);
   localparam int NCOUNT_WIDTH = $clog2(MAX_VERTICES + 1);
   localparam int CMP_WIDTH    = (COUNT_WIDTH > NCOUNT_WIDTH) ? COUNT_WIDTH : NCOUNT_WIDTH;
   localparam int DIFF_WIDTH   = COORD_WIDTH + 1;
   localparam int PROD_WIDTH   = 2 * DIFF_WIDTH;

   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [DIFF_WIDTH-1:0]  diff_type;
   typedef logic signed [PROD_WIDTH-1:0]  prod_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

   // Per-cycle control from the sequencer to the edge unit.
   typedef struct packed {
      logic clear;   // new query: drop all accumulated results
      logic step;    // an edge in use is at the head of the ring
      logic first;   // the head holds vertex 0
      logic last;    // the head holds the last vertex in use
   } edge_ctl_type;

   function automatic diff_type widen(coord_type v);
      return {v[COORD_WIDTH-1], v};
   endfunction

endpackage
`default_nettype wire

// ===== rtl/ppt_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Vertex ring cell
// Holds one polygon vertex; loads on a write, takes its neighbor's on a shift.
// ----------------------------------------------------------------------------
module ppt_cell (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic               shift,
   input  wire ppt_pkg::vertex_type load_vertex,
   input  wire ppt_pkg::vertex_type next_vertex,
   output      ppt_pkg::vertex_type vertex
);

   ppt_pkg::vertex_type vertex_ff;
   ppt_pkg::vertex_type vertex_in;

   always_comb begin
      vertex_in = vertex_ff;
      if (load) begin
         vertex_in = load_vertex;
      end else if (shift) begin
         vertex_in = next_vertex;
      end
   end

   always_ff @(posedge clock) begin
      vertex_ff <= vertex_in;
   end

   assign vertex = vertex_ff;

endmodule
`default_nettype wire

// ===== rtl/ppt_edge_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Polygon edge unit
// Tests one edge per cycle against the query point: bounding box, on-edge
// check and even-odd crossing count, in a two-stage pipeline.
// ----------------------------------------------------------------------------
module ppt_edge_unit (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ppt_pkg::edge_ctl_type ctl,
   input  wire ppt_pkg::coord_type    query_x,
   input  wire ppt_pkg::coord_type    query_y,
   input  wire ppt_pkg::vertex_type   cur_vertex,
   input  wire ppt_pkg::vertex_type   next_vertex,
   output      logic                  in_poly
);

   ppt_pkg::vertex_type first_now;
   ppt_pkg::vertex_type first_ff, first_in;
   ppt_pkg::coord_type  ax, ay, bx, by;
   ppt_pkg::diff_type   dqx, dy, dbx, dqy;

   ppt_pkg::prod_type   p1_ff, p1_in, p2_ff, p2_in;
   logic                straddle_ff, straddle_in;
   logic                dy_pos_ff, dy_pos_in;
   logic                extent_ff, extent_in;
   logic                pv_ff, pv_in;

   ppt_pkg::coord_type  min_x_ff, min_x_in, max_x_ff, max_x_in;
   ppt_pkg::coord_type  min_y_ff, min_y_in, max_y_ff, max_y_in;
   logic                any_ff, any_in;
   logic                on_edge_ff, on_edge_in;
   logic                odd_ff, odd_in;

   logic                c_zero, c_lt, c_gt, crosses;

   // Stage A: differences, the two cross products and the edge flags.
   always_comb begin
      first_now = ctl.first ? cur_vertex : first_ff;
      ax = cur_vertex.x;
      ay = cur_vertex.y;
      if (ctl.last) begin
         bx = first_now.x;
         by = first_now.y;
      end else begin
         bx = next_vertex.x;
         by = next_vertex.y;
      end

      dqx = ppt_pkg::widen(query_x) - ppt_pkg::widen(ax);
      dy  = ppt_pkg::widen(by) - ppt_pkg::widen(ay);
      dbx = ppt_pkg::widen(bx) - ppt_pkg::widen(ax);
      dqy = ppt_pkg::widen(query_y) - ppt_pkg::widen(ay);

      p1_in       = dqx * dy;
      p2_in       = dbx * dqy;
      straddle_in = (ay > query_y) != (by > query_y);
      dy_pos_in   = by > ay;
      extent_in   = ((ax <= query_x) || (bx <= query_x)) &&
                    ((ax >= query_x) || (bx >= query_x)) &&
                    ((ay <= query_y) || (by <= query_y)) &&
                    ((ay >= query_y) || (by >= query_y));
      pv_in       = ctl.step;

      first_in = (ctl.step && ctl.first) ? cur_vertex : first_ff;

      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      if (ctl.step) begin
         if (ctl.first) begin
            min_x_in = ax;
            max_x_in = ax;
            min_y_in = ay;
            max_y_in = ay;
         end else begin
            if (ax < min_x_ff) min_x_in = ax;
            if (ax > max_x_ff) max_x_in = ax;
            if (ay < min_y_ff) min_y_in = ay;
            if (ay > max_y_ff) max_y_in = ay;
         end
      end
      any_in = ctl.clear ? 1'b0 : (any_ff || ctl.step);
   end

   // Stage B: sign of the cross product difference decides both tests.
   always_comb begin
      c_zero  = p1_ff == p2_ff;
      c_lt    = p1_ff < p2_ff;
      c_gt    = !c_zero && !c_lt;
      crosses = dy_pos_ff ? c_lt : c_gt;

      on_edge_in = on_edge_ff;
      odd_in     = odd_ff;
      if (ctl.clear) begin
         on_edge_in = 1'b0;
         odd_in     = 1'b0;
      end else if (pv_ff) begin
         on_edge_in = on_edge_ff || (c_zero && extent_ff);
         odd_in     = odd_ff ^ (straddle_ff && crosses);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff      <= 1'b0;
         any_ff     <= 1'b0;
         on_edge_ff <= 1'b0;
         odd_ff     <= 1'b0;
      end else begin
         pv_ff      <= pv_in;
         any_ff     <= any_in;
         on_edge_ff <= on_edge_in;
         odd_ff     <= odd_in;
      end
   end

   always_ff @(posedge clock) begin
      p1_ff       <= p1_in;
      p2_ff       <= p2_in;
      straddle_ff <= straddle_in;
      dy_pos_ff   <= dy_pos_in;
      extent_ff   <= extent_in;
      first_ff    <= first_in;
      min_x_ff    <= min_x_in;
      max_x_ff    <= max_x_in;
      min_y_ff    <= min_y_in;
      max_y_ff    <= max_y_in;
   end

   assign in_poly = any_ff &&
                    (query_x >= min_x_ff) && (query_x <= max_x_ff) &&
                    (query_y >= min_y_ff) && (query_y <= max_y_ff) &&
                    (on_edge_ff || odd_ff);

endmodule
`default_nettype wire

// ===== rtl/point_in_polygon_test.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point-in-polygon test
// Stores polygon vertices in a ring of cells and answers point queries with
// an inside flag using a bounding box, an on-edge check and ray casting.
// ----------------------------------------------------------------------------
// A query holds busy through the RUN, DRAIN and FIN states, and its result
// strobe rises in the same cycle in which busy drops. Busy covers one full
// rotation of the vertex ring past the single edge unit; a new query is
// taken only in an idle cycle after busy drops, and a vertex write finishes
// in the cycle in which it is taken.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset clears the sequencer, the result strobe and vertex_count; the vertex
// store is not cleared and must be written before it is queried.
// ----------------------------------------------------------------------------
module point_in_polygon_test (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output      logic                                busy,
   input  wire logic                                req_opcode,
   input  wire logic [ppt_pkg::INDEX_WIDTH-1:0]     req_vertex_index,
   input  wire logic signed [ppt_pkg::COORD_WIDTH-1:0] req_coord_x,
   input  wire logic signed [ppt_pkg::COORD_WIDTH-1:0] req_coord_y,
   output      logic                                rsp_valid,
   output      logic                                rsp_inside_res,
   input  wire logic                                csr_wr_en,
   input  wire logic [ppt_pkg::COUNT_WIDTH-1:0]     csr_wr_data
);

   // Sequencer states.
   localparam logic [1:0] ST_IDLE  = 2'd0;  // waiting for a transfer
   localparam logic [1:0] ST_RUN   = 2'd1;  // ring rotating, one edge a cycle
   localparam logic [1:0] ST_DRAIN = 2'd2;  // last edge leaves the pipeline
   localparam logic [1:0] ST_FIN   = 2'd3;  // result captured for the strobe

   logic [1:0]                         state_ff, state_in;
   logic [ppt_pkg::STEP_WIDTH-1:0]     step_ff, step_in;
   logic [ppt_pkg::COUNT_WIDTH-1:0]    count_ff, count_in;
   ppt_pkg::coord_type                 qx_ff, qx_in, qy_ff, qy_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   logic                               rsp_inside_ff, rsp_inside_in;

   logic                               accept;
   logic                               write_accept;
   logic                               query_accept;
   logic                               shift;
   logic [ppt_pkg::NCOUNT_WIDTH-1:0]   n_used;
   logic [ppt_pkg::NCOUNT_WIDTH-1:0]   step_wide;
   logic [ppt_pkg::NCOUNT_WIDTH-1:0]   step_next;
   logic                               step_last;
   logic [ppt_pkg::MAX_VERTICES-1:0]   cell_load;
   ppt_pkg::vertex_type                req_vertex;
   ppt_pkg::vertex_type                ring [ppt_pkg::MAX_VERTICES];
   ppt_pkg::edge_ctl_type              edge_ctl;
   logic                               in_poly;

   // A transfer is taken whenever the sequencer is idle. Writes finish in
   // the cycle they are taken, so only queries raise busy.
   assign busy         = state_ff != ST_IDLE;
   assign accept       = start && !busy;
   assign write_accept = accept && (req_opcode == ppt_pkg::OP_WRITE);
   assign query_accept = accept && (req_opcode == ppt_pkg::OP_QUERY);

   assign req_vertex.x = req_coord_x;
   assign req_vertex.y = req_coord_y;

   // The register may name more vertices than the ring holds; it saturates.
   assign n_used = (ppt_pkg::CMP_WIDTH'(count_ff) > ppt_pkg::CMP_WIDTH'(ppt_pkg::MAX_VERTICES))
                   ? ppt_pkg::NCOUNT_WIDTH'(ppt_pkg::MAX_VERTICES)
                   : ppt_pkg::NCOUNT_WIDTH'(count_ff);

   // The ring rotates toward cell 0. After k shifts cell 0 holds vertex k and
   // cell 1 holds vertex k+1, so each cycle presents one edge to the edge
   // unit. A query always makes a full rotation, which leaves every vertex
   // back in its home cell for the next write.
   assign shift = state_ff == ST_RUN;

   for (genvar i = 0; i < ppt_pkg::MAX_VERTICES; i++) begin : g_cell
      localparam int NEXT = (i + 1) % ppt_pkg::MAX_VERTICES;

      assign cell_load[i] = write_accept && (int'(req_vertex_index) == i);

      ppt_cell u_cell (
         .clock       (clock),
         .load        (cell_load[i]),
         .shift       (shift),
         .load_vertex (req_vertex),
         .next_vertex (ring[NEXT]),
         .vertex      (ring[i])
      );
   end

   // Only the first n_used steps of the rotation carry edges in use. The
   // edge from the last vertex closes back to vertex 0, which the edge unit
   // keeps from the first step.
   assign step_wide = ppt_pkg::NCOUNT_WIDTH'(step_ff);
   assign step_next = step_wide + ppt_pkg::NCOUNT_WIDTH'(1);
   assign step_last = step_ff == ppt_pkg::STEP_WIDTH'(ppt_pkg::MAX_VERTICES - 1);

   always_comb begin
      edge_ctl.clear = query_accept;
      edge_ctl.step  = (state_ff == ST_RUN) && (step_wide < n_used);
      edge_ctl.first = step_ff == '0;
      edge_ctl.last  = step_next == n_used;
   end

   ppt_edge_unit u_edge (
      .clock       (clock),
      .reset       (reset),
      .ctl         (edge_ctl),
      .query_x     (qx_ff),
      .query_y     (qy_ff),
      .cur_vertex  (ring[0]),
      .next_vertex (ring[1]),
      .in_poly     (in_poly)
   );

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      count_in      = csr_wr_en ? csr_wr_data : count_ff;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = rsp_inside_ff;

      case (state_ff)
         ST_IDLE: begin
            if (query_accept) begin
               state_in = ST_RUN;
               step_in  = '0;
               qx_in    = req_coord_x;
               qy_in    = req_coord_y;
            end
         end
         ST_RUN: begin
            step_in = step_ff + ppt_pkg::STEP_WIDTH'(1);
            if (step_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            state_in      = ST_IDLE;
            rsp_valid_in  = 1'b1;
            rsp_inside_in = in_poly;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      qx_ff         <= qx_in;
      qy_ff         <= qy_in;
      rsp_inside_ff <= rsp_inside_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;

endmodule
`default_nettype wire

// ===== rtl/ppt_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Point-in-polygon port checker
// Watches the top-level ports for sequencing and result strobe rules.
// ----------------------------------------------------------------------------
module ppt_checker (
   input wire logic                                   clock,
   input wire logic                                   reset,
   input wire logic                                   start,
   input wire logic                                   busy,
   input wire logic                                   req_opcode,
   input wire logic                                   rsp_valid
);

   // A query transfer starts the rotation.
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == ppt_pkg::OP_QUERY) |=> busy)
      else $error("query transfer did not raise busy");

   // A vertex write finishes at once and produces no result.
   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_opcode == ppt_pkg::OP_WRITE) |=> !busy && !rsp_valid)
      else $error("vertex write raised busy or a result");

   // The end of a query always brings its result.
   a_fall_result: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result strobe");

   // A result strobe lasts one cycle and never overlaps a running query.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy ##1 !rsp_valid)
      else $error("result strobe longer than one cycle or during busy");

endmodule

bind point_in_polygon_test ppt_checker u_ppt_checker (.*);
`default_nettype wire
